// ===== rtl/kbd_pkg.sv =====
// ----------------------------------------------------------------------------
// kbd_pkg
// Shared constants and types for the keyboard report change event block.
// ----------------------------------------------------------------------------
package kbd_pkg;

	// Report geometry: the key slots are fixed by the boot report layout.
	localparam int KEY_SLOTS   = 6;
	localparam int MOD_COUNT   = 8;
	localparam int USAGE_W     = 8;
	localparam int EVENT_COUNT = MOD_COUNT + 2 * KEY_SLOTS;

	// First modifier usage; modifier bit i maps to MOD_BASE + i.
	localparam logic [USAGE_W-1:0] MOD_BASE = 8'hE0;

	typedef logic [USAGE_W-1:0]     usage_t;
	typedef logic [MOD_COUNT-1:0]   mods_t;
	typedef logic [EVENT_COUNT-1:0] ev_mask_t;

	// One report's pending events: modifier changes in the low bits, then
	// releases by old slot, then presses by new slot.
	typedef struct packed {
		ev_mask_t                  mask;
		usage_t [KEY_SLOTS-1:0]    old_keys;
		usage_t [KEY_SLOTS-1:0]    new_keys;
		mods_t                     new_mods;
	} ev_set_t;

endpackage

// ===== rtl/kbd_report_if.sv =====
// ----------------------------------------------------------------------------
// kbd_report_if
// Valid/ready channel that carries one boot keyboard report per beat.
// ----------------------------------------------------------------------------
interface kbd_report_if;
	import kbd_pkg::*;

	logic   valid;
	logic   ready;
	mods_t  modifier_bits;
	usage_t key_slot_0;
	usage_t key_slot_1;
	usage_t key_slot_2;
	usage_t key_slot_3;
	usage_t key_slot_4;
	usage_t key_slot_5;

	modport source (
		output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
		       key_slot_3, key_slot_4, key_slot_5,
		input  ready
	);

	modport sink (
		input  valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
		       key_slot_3, key_slot_4, key_slot_5,
		output ready
	);

endinterface

// ===== rtl/kbd_event_if.sv =====
// ----------------------------------------------------------------------------
// kbd_event_if
// Valid/ready channel that carries one key press or release per beat.
// ----------------------------------------------------------------------------
interface kbd_event_if;
	import kbd_pkg::*;

	logic   valid;
	logic   ready;
	usage_t usage_code;
	logic   is_press;
	logic   last_event;

	modport source (
		output valid, usage_code, is_press, last_event,
		input  ready
	);

	modport sink (
		input  valid, usage_code, is_press, last_event,
		output ready
	);

endinterface

// ===== rtl/keyboard_report_change_events.sv =====
// ----------------------------------------------------------------------------
// keyboard_report_change_events
// Turns a stream of boot keyboard reports into key press and release beats.
// Each accepted report is compared with the one before it (all zero after
// reset); the block sends modifier changes for bits 0 to 7 as usages E0 to
// E7, then releases of old keys missing from the new report in slot order,
// then presses of new keys missing from the old report in slot order, with
// last_event set on the final beat of a report. The emitter sends one event
// beat per cycle while the receiver is ready, through the single output
// register. Acceptance loads the pending event set, and the first beat then
// moves into the output register. A report with no changes sends nothing.
// The next report is accepted in the cycle that the previous report's final
// event moves into the output register, so report ready follows event ready
// combinationally.
// ----------------------------------------------------------------------------
module keyboard_report_change_events (
	input  logic          clk,
	input  logic          arst_n,
	kbd_report_if.sink    report,
	kbd_event_if.source   change
);
	import kbd_pkg::*;

	logic                   accept;
	logic                   can_load;
	usage_t [KEY_SLOTS-1:0] keys_in;
	ev_set_t                ev_set;

	// Gather the slots into an array, slot 0 lowest.
	assign keys_in = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
	                  report.key_slot_2, report.key_slot_1, report.key_slot_0};

	assign report.ready = can_load;
	assign accept       = report.valid && can_load;

	kbd_diff u_diff (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.mods_in (report.modifier_bits),
		.keys_in (keys_in),
		.ev_set  (ev_set)
	);

	kbd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.set_in    (ev_set),
		.can_load  (can_load),
		.out_ready (change.ready),
		.out_valid (change.valid),
		.out_usage (change.usage_code),
		.out_press (change.is_press),
		.out_last  (change.last_event)
	);

endmodule

// ===== rtl/kbd_diff.sv =====
// ----------------------------------------------------------------------------
// kbd_diff
// Holds the previous report and compares an incoming report against it,
// producing the set of pending events. The stored report is replaced on
// every accepted beat.
// ----------------------------------------------------------------------------
module kbd_diff (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      accept,
	input  kbd_pkg::mods_t                            mods_in,
	input  kbd_pkg::usage_t [kbd_pkg::KEY_SLOTS-1:0]  keys_in,
	output kbd_pkg::ev_set_t                          ev_set
);
	import kbd_pkg::*;

	usage_t [KEY_SLOTS-1:0] prev_keys_q;
	mods_t                  prev_mods_q;

	logic [KEY_SLOTS-1:0] old_in_new;
	logic [KEY_SLOTS-1:0] new_in_old;
	logic [KEY_SLOTS-1:0] release_mask;
	logic [KEY_SLOTS-1:0] press_mask;

	// Cross-compare every old slot with every new slot.
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			old_in_new[i] = 1'b0;
			new_in_old[i] = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (prev_keys_q[i] == keys_in[j]) begin
					old_in_new[i] = 1'b1;
				end
				if (keys_in[i] == prev_keys_q[j]) begin
					new_in_old[i] = 1'b1;
				end
			end
			release_mask[i] = (prev_keys_q[i] != '0) && !old_in_new[i];
			press_mask[i]   = (keys_in[i] != '0) && !new_in_old[i];
		end
	end

	// Pack the pending events in emission order, lowest bit first.
	always_comb begin
		ev_set.mask     = {press_mask, release_mask, prev_mods_q ^ mods_in};
		ev_set.old_keys = prev_keys_q;
		ev_set.new_keys = keys_in;
		ev_set.new_mods = mods_in;
	end

	// The new report becomes the reference for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q <= '0;
			prev_mods_q <= '0;
		end else if (accept) begin
			prev_keys_q <= keys_in;
			prev_mods_q <= mods_in;
		end
	end

endmodule

// ===== rtl/kbd_emit.sv =====
// ----------------------------------------------------------------------------
// kbd_emit
// Holds one report's pending events and sends them one per cycle while the
// output is free, lowest pending first, through a registered output stage.
// ----------------------------------------------------------------------------
module kbd_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  kbd_pkg::ev_set_t  set_in,
	output logic              can_load,
	input  logic              out_ready,
	output logic              out_valid,
	output kbd_pkg::usage_t   out_usage,
	output logic              out_press,
	output logic              out_last
);
	import kbd_pkg::*;

	ev_mask_t               pend_q;
	usage_t [KEY_SLOTS-1:0] old_keys_q;
	usage_t [KEY_SLOTS-1:0] new_keys_q;
	mods_t                  new_mods_q;

	logic   out_valid_q;
	usage_t out_usage_q;
	logic   out_press_q;
	logic   out_last_q;

	ev_mask_t                 low_bit;
	ev_mask_t                 remain;
	logic                     out_free;
	logic                     pop;
	usage_t [EVENT_COUNT-1:0] cand_usage;
	logic [EVENT_COUNT-1:0]   cand_press;
	usage_t                   sel_usage;
	logic                     sel_press;

	// Pick the lowest pending event and see what stays behind.
	always_comb begin
		low_bit  = pend_q & (~pend_q + 1'b1);
		remain   = pend_q & ~low_bit;
		out_free = !out_valid_q || out_ready;
		pop      = (pend_q != '0) && out_free;
		can_load = (pend_q == '0) || (pop && (remain == '0));
	end

	// Usage and direction of every possible event.
	always_comb begin
		for (int i = 0; i < MOD_COUNT; i++) begin
			cand_usage[i] = MOD_BASE + USAGE_W'(i);
			cand_press[i] = new_mods_q[i];
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			cand_usage[MOD_COUNT + i]             = old_keys_q[i];
			cand_press[MOD_COUNT + i]             = 1'b0;
			cand_usage[MOD_COUNT + KEY_SLOTS + i] = new_keys_q[i];
			cand_press[MOD_COUNT + KEY_SLOTS + i] = 1'b1;
		end
	end

	// One-hot select of the chosen event.
	always_comb begin
		sel_usage = '0;
		sel_press = 1'b0;
		for (int i = 0; i < EVENT_COUNT; i++) begin
			sel_usage = sel_usage | ({USAGE_W{low_bit[i]}} & cand_usage[i]);
			sel_press = sel_press | (low_bit[i] & cand_press[i]);
		end
	end

	// Pending event set: a new report replaces it once the old one is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= set_in.mask;
		end else if (pop) begin
			pend_q <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			old_keys_q <= set_in.old_keys;
			new_keys_q <= set_in.new_keys;
			new_mods_q <= set_in.new_mods;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_usage_q <= sel_usage;
			out_press_q <= sel_press;
			out_last_q  <= (remain == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_usage = out_usage_q;
	assign out_press = out_press_q;
	assign out_last  = out_last_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyboard_report_change_events. Boot keyboard reports
// go in on the report channel. A local copy of the stored report works out the
// modifier, release and press beats that each accepted report must cause.
// Every beat on the change channel is matched in order against that list.
// Directed cases come first, then evolving random reports under three mixes
// of sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kbd_pkg::*;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 25;
	localparam int RANDOM_ITEMS  = 100;

	// One expected beat on the change channel.
	typedef struct packed {
		usage_t usage;
		logic   press;
		logic   last;
	} key_change_t;

	logic clk = 1'b0;
	logic arst_n;

	kbd_report_if report_ch ();
	kbd_event_if  change_ch ();

	keyboard_report_change_events dut (
		.clk    (clk),
		.arst_n (arst_n),
		.report (report_ch),
		.change (change_ch)
	);

	// The report that the block holds, as seen from outside.
	usage_t [KEY_SLOTS-1:0] prior_keys;
	mods_t                  prior_mods;

	key_change_t pending_changes[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int reports_sent  = 0;
	int beats_checked = 0;
	int cycle_count   = 0;

	always #5 clk = ~clk;

	// A run that hangs ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats still expected", $time,
				pending_changes.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic bit slot_has(input usage_t [KEY_SLOTS-1:0] slots, input usage_t code);
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (slots[j] == code)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Work out the beats of one report: modifier changes, then releases of
	// old keys, then presses of new keys. The report then becomes the prior one.
	function automatic void predict_changes(input mods_t mods,
			input usage_t [KEY_SLOTS-1:0] keys);
		key_change_t found[$];
		key_change_t c;
		c.last = 1'b0;
		for (int i = 0; i < MOD_COUNT; i++) begin
			if (prior_mods[i] != mods[i]) begin
				c.usage = MOD_BASE + usage_t'(i);
				c.press = mods[i];
				found.push_back(c);
			end
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (prior_keys[i] != '0 && !slot_has(keys, prior_keys[i])) begin
				c.usage = prior_keys[i];
				c.press = 1'b0;
				found.push_back(c);
			end
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (keys[i] != '0 && !slot_has(prior_keys, keys[i])) begin
				c.usage = keys[i];
				c.press = 1'b1;
				found.push_back(c);
			end
		end
		if (found.size() > 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[i])
			pending_changes.push_back(found[i]);
		prior_keys = keys;
		prior_mods = mods;
	endfunction

	// Receiver side: random ready, and each change beat checked in order.
	always @(posedge clk) begin
		key_change_t want;
		change_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && change_ch.valid && change_ch.ready) begin
			beats_checked++;
			if (pending_changes.size() == 0) begin
				error_count++;
				$display("%0t: unexpected beat: usage %02h press %0b last %0b", $time,
					change_ch.usage_code, change_ch.is_press, change_ch.last_event);
			end else begin
				want = pending_changes.pop_front();
				if (change_ch.usage_code !== want.usage || change_ch.is_press !== want.press
						|| change_ch.last_event !== want.last) begin
					error_count++;
					$display({"%0t: beat mismatch: expected usage %02h press %0b last %0b,",
						" got usage %02h press %0b last %0b"},
						$time, want.usage, want.press, want.last,
						change_ch.usage_code, change_ch.is_press, change_ch.last_event);
				end
			end
		end
	end

	// Offer one report after a random gap and hold it until it is taken.
	// Valid stays high afterwards so that back-to-back reports need no drop.
	task automatic send_report(input mods_t mods, input usage_t k0, input usage_t k1,
			input usage_t k2, input usage_t k3, input usage_t k4, input usage_t k5);
		usage_t [KEY_SLOTS-1:0] keys;
		keys = {k5, k4, k3, k2, k1, k0};
		while ($urandom_range(99) < send_idle_pct) begin
			report_ch.valid <= 1'b0;
			@(posedge clk);
		end
		report_ch.valid         <= 1'b1;
		report_ch.modifier_bits <= mods;
		report_ch.key_slot_0    <= k0;
		report_ch.key_slot_1    <= k1;
		report_ch.key_slot_2    <= k2;
		report_ch.key_slot_3    <= k3;
		report_ch.key_slot_4    <= k4;
		report_ch.key_slot_5    <= k5;
		@(posedge clk);
		while (!report_ch.ready)
			@(posedge clk);
		predict_changes(mods, keys);
		reports_sent++;
	endtask

	// Stop sending and let every expected beat come out, then let the block settle.
	task automatic wait_drained();
		report_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_changes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// An all-zero report right after reset changes nothing.
	task automatic test_quiet_report();
		send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// All modifiers on, unchanged, off, then alternating patterns.
	task automatic test_modifier_sweep();
		send_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// Full slots, a reordering with no change, the longest report of all,
	// sparse slots with the extreme usages, and clearing.
	task automatic test_key_slots();
		send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
		send_report(8'h00, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04);
		send_report(8'hFF, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F);
		send_report(8'h00, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h0A, 8'h00);
		send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// A repeated usage is pressed per new slot and released per old slot once gone.
	task automatic test_repeated_usages();
		send_report(8'h00, 8'h10, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h20);
		send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// Modifier usages in key slots are ordinary keys, apart from the byte.
	task automatic test_modifier_usages_in_slots();
		send_report(8'h01, 8'hE0, 8'hE7, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h00, 8'hE0, 8'hE7, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// Mostly reports that evolve from the prior one, so keys are held, moved,
	// dropped and added; some exact repeats and some fully random noise.
	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		usage_t [KEY_SLOTS-1:0] keys;
		mods_t                  mods;
		int                     kind;
		int                     pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(99);
			keys = prior_keys;
			mods = prior_mods;
			if (kind < 10) begin
				mods = mods_t'($urandom);
				for (int i = 0; i < KEY_SLOTS; i++)
					keys[i] = usage_t'($urandom);
			end else if (kind >= 18) begin
				if ($urandom_range(9) == 0)
					mods = mods_t'($urandom);
				else
					mods = prior_mods ^ mods_t'($urandom & $urandom & $urandom);
				for (int i = 0; i < KEY_SLOTS; i++) begin
					pick = $urandom_range(9);
					if (pick == 5 || pick == 6)
						keys[i] = '0;
					else if (pick == 7 || pick == 8)
						keys[i] = usage_t'($urandom_range(4, 12));
					else if (pick == 9) begin
						case ($urandom_range(3))
							0: keys[i] = prior_keys[$urandom_range(KEY_SLOTS-1)];
							1: keys[i] = MOD_BASE + usage_t'($urandom_range(MOD_COUNT-1));
							2: keys[i] = 8'hFF;
							default: keys[i] = usage_t'($urandom_range(1, 255));
						endcase
					end
				end
			end
			send_report(mods, keys[0], keys[1], keys[2], keys[3], keys[4], keys[5]);
			// Halfway through, hold off until the block has emptied out.
			if (n == count / 2)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n                  = 1'b0;
		report_ch.valid         = 1'b0;
		report_ch.modifier_bits = '0;
		report_ch.key_slot_0    = '0;
		report_ch.key_slot_1    = '0;
		report_ch.key_slot_2    = '0;
		report_ch.key_slot_3    = '0;
		report_ch.key_slot_4    = '0;
		report_ch.key_slot_5    = '0;
		change_ch.ready         = 1'b0;
		prior_keys              = '0;
		prior_mods              = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 15;
		recv_idle_pct = 30;
		test_quiet_report();
		test_modifier_sweep();
		test_key_slots();
		wait_drained();
		test_repeated_usages();
		test_modifier_usages_in_slots();
		wait_drained();

		test_random_traffic(21, 70, RANDOM_ITEMS);
		test_random_traffic(70, 21, RANDOM_ITEMS);
		test_random_traffic(0, 0, RANDOM_ITEMS);

		$display("summary: %0d reports sent, %0d change beats checked", reports_sent,
			beats_checked);
		$display("summary: directed edge cases, then random reports under three idle mixes");
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
